// ----- rtl/dqxs_pkg.sv -----
// shared constants and types for the deque with exchange sort
// no dependencies; imported by every module of the block
package dqxs_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int OP_W          = 2;
    localparam int CNT_OUT_W     = 5;
    localparam int STATUS_W      = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_HEAD = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_TAIL = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_TAIL  = 2'd2;
    localparam logic [OP_W-1:0] OP_SORT      = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // one result transfer
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [CNT_OUT_W-1:0]      count;
        logic [STATUS_W-1:0]       status;
    } t_result;

endpackage

// ----- rtl/dqxs_ram.sv -----
// generic single-write, single-read memory with registered read data
// depends on dqxs_pkg for default sizes
module dqxs_ram
    import dqxs_pkg::*;
#(
    parameter int WIDTH = VALUE_W,
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds while no read is issued
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/deque_with_exchange_sort.sv -----
// top level of the bounded deque of signed values with in-place exchange sort
// depends on dqxs_pkg and dqxs_ram
//
// Bounded double-ended queue of DEPTH signed 32-bit values kept in a circular
// store in one RAM (one write and one registered read port). Each input
// transfer carries one operation (push at head, push at tail, pop from tail,
// sort ascending head to tail) and yields exactly one output transfer with
// the popped value, the entry count after the operation and a status. A push
// is written when accepted, and the next operation may follow at once unless
// the output is stalled. A pop reads the tail entry from the RAM, and S_POP
// passes it to the output register once that is free. A sort makes one signed
// compare per cycle in S_CMP on the shared comparator, with the running value
// of the current position held in a register and each later position read,
// compared and written back through the single RAM read and write ports.
// The input is stalled while an operation is in progress and while a finished
// result waits in the output register with the output stalled. The store is
// not cleared at reset; only entries written since are ever read.
module deque_with_exchange_sort
    import dqxs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [OP_W-1:0]             i_operation,
    input  logic signed [VALUE_W-1:0]   i_value,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [VALUE_W-1:0]   o_popped_value,
    output logic [CNT_OUT_W-1:0]        o_entry_count,
    output logic [STATUS_W-1:0]         o_status
);

    localparam int AW = $clog2(DEPTH);       // store address width
    localparam int CW = $clog2(DEPTH + 1);   // count width, holds DEPTH itself
    localparam int SW = CW + 1;              // head plus offset, before wrap

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,      // tail read in flight, result on next free output slot
        S_CAP_I,    // capture value at position i, read position j
        S_CMP,      // compare held value against position j, swap if greater
        S_WR_I,     // write back the smallest value found for position i
        S_DONE      // sort finished, hand out the result
    } t_state;

    // physical slot of logical position k (0 is the head)
    function automatic logic [AW-1:0] wrap_slot(input logic [AW-1:0] base,
                                                input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(k);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // state and registered outputs
    t_state                    r_state, n_state;
    logic [AW-1:0]             r_head, n_head;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_i, n_i;          // sort: outer position
    logic [CW-1:0]             r_j, n_j;          // sort: inner position
    logic signed [VALUE_W-1:0] r_x, n_x;          // sort: running value of position i
    logic                      r_out_valid, n_out_valid;
    t_result                   r_out, n_out;

    // ram port controls
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [VALUE_W-1:0]        ram_wdata;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [VALUE_W-1:0]        ram_rdata;
    logic signed [VALUE_W-1:0] rd_value;

    logic                      in_accept;
    logic                      out_free;
    logic [AW-1:0]             head_dec;

    dqxs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    assign rd_value = $signed(ram_rdata);

    // output slot is free if empty or being drained this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !i_rst_n || (r_state != S_IDLE) || !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // head moves down one slot on a push at the head
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : (r_head - AW'(1));

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_i         = r_i;
        n_j         = r_j;
        n_x         = r_x;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_waddr   = r_head;
        ram_wdata   = r_x;
        ram_re      = 1'b0;
        ram_raddr   = r_head;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (i_operation)
                        OP_PUSH_HEAD, OP_PUSH_TAIL: begin
                            n_out_valid = 1'b1;
                            n_out.value = '0;
                            if (r_count == CW'(DEPTH)) begin
                                // full: drop the value
                                n_out.count  = CNT_OUT_W'(r_count);
                                n_out.status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = i_value;
                                if (i_operation == OP_PUSH_HEAD) begin
                                    ram_waddr = head_dec;
                                    n_head    = head_dec;
                                end else begin
                                    ram_waddr = wrap_slot(r_head, r_count);
                                end
                                n_count      = r_count + CW'(1);
                                n_out.count  = CNT_OUT_W'(r_count + CW'(1));
                                n_out.status = ST_OK;
                            end
                        end
                        OP_POP_TAIL: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out.value  = '0;
                                n_out.count  = '0;
                                n_out.status = ST_EMPTY;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = wrap_slot(r_head, r_count - CW'(1));
                                n_count   = r_count - CW'(1);
                                n_state   = S_POP;
                            end
                        end
                        default: begin
                            // sort; nothing to do below two entries
                            if (r_count < CW'(2)) begin
                                n_out_valid  = 1'b1;
                                n_out.value  = '0;
                                n_out.count  = CNT_OUT_W'(r_count);
                                n_out.status = ST_OK;
                            end else begin
                                n_i       = '0;
                                ram_re    = 1'b1;
                                ram_raddr = r_head;
                                n_state   = S_CAP_I;
                            end
                        end
                    endcase
                end
            end
            S_POP: begin
                // read data holds until taken
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out.value  = rd_value;
                    n_out.count  = CNT_OUT_W'(r_count);
                    n_out.status = ST_OK;
                    n_state      = S_IDLE;
                end
            end
            S_CAP_I: begin
                n_x       = rd_value;
                n_j       = r_i + CW'(1);
                ram_re    = 1'b1;
                ram_raddr = wrap_slot(r_head, r_i + CW'(1));
                n_state   = S_CMP;
            end
            S_CMP: begin
                // shared signed comparator; equal values stay in place
                if (r_x > rd_value) begin
                    ram_we    = 1'b1;
                    ram_waddr = wrap_slot(r_head, r_j);
                    ram_wdata = r_x;
                    n_x       = rd_value;
                end
                if ((r_j + CW'(1)) < r_count) begin
                    n_j       = r_j + CW'(1);
                    ram_re    = 1'b1;
                    ram_raddr = wrap_slot(r_head, r_j + CW'(1));
                end else begin
                    n_state = S_WR_I;
                end
            end
            S_WR_I: begin
                ram_we    = 1'b1;
                ram_waddr = wrap_slot(r_head, r_i);
                ram_wdata = r_x;
                if ((r_i + CW'(2)) < r_count) begin
                    n_i       = r_i + CW'(1);
                    ram_re    = 1'b1;
                    ram_raddr = wrap_slot(r_head, r_i + CW'(1));
                    n_state   = S_CAP_I;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out.value  = '0;
                    n_out.count  = CNT_OUT_W'(r_count);
                    n_out.status = ST_OK;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_i         <= n_i;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
        // payload, no reset
        r_x   <= n_x;
        r_out <= n_out;
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_out.value;
    assign o_entry_count  = r_out.count;
    assign o_status       = r_out.status;

`ifndef SYNTHESIS
    // occupancy never goes past the store size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    // sort never writes and reads the same slot in one cycle
    a_no_same_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("ram read and write collide");

    // a pop on a non-empty queue removes exactly one entry
    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_operation == OP_POP_TAIL) && (r_count != '0))
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not decrement count");

    // count changes only when an operation is accepted
    a_busy_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && (r_state != S_IDLE)) |=> $stable(r_count))
        else $error("count moved while busy");
`endif

endmodule

// ----- tb/sv/deque_with_exchange_sort_tb.sv -----
// self-checking testbench for the bounded deque with in-place exchange sort
// depends on dqxs_pkg and the deque_with_exchange_sort rtl, which needs dqxs_ram
`timescale 1ns / 100ps

module deque_with_exchange_sort_tb;
    import dqxs_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    // slowest run: every item a full sort plus the longest gap and the longest stall,
    // ~730 items; the timeout allows five times that
    localparam int TIMEOUT_NS = 8_500_000;
    localparam int RANDOM_OPS = 700;
    localparam int MAX_PRINTS = 40;

    // one entry of the stimulus backlog; a hold entry makes the sender wait
    // until every awaited reply has come back
    typedef struct packed {
        logic                      hold;
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] val;
    } t_op_item;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [OP_W-1:0]           i_operation = OP_PUSH_HEAD;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [VALUE_W-1:0] o_popped_value;
    logic [CNT_OUT_W-1:0]      o_entry_count;
    logic [STATUS_W-1:0]       o_status;

    deque_with_exchange_sort #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_popped_value (o_popped_value),
        .o_entry_count  (o_entry_count),
        .o_status       (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // stimulus backlog and the replies the deque owes us, oldest first
    t_op_item op_backlog[$];
    t_result  reply_queue[$];

    // our own copy of the deque contents
    logic signed [VALUE_W-1:0] shadow_store[DEPTH];
    int shadow_head = 0;
    int shadow_fill = 0;

    // gap state: [0] sender, [1] receiver
    int quiet_left[2] = '{0, 0};
    int send_gap = 0;
    int stall_left = 0;

    int error_count = 0;
    int reply_index = 0;

    // what the run went through
    int n_push_head = 0;
    int n_push_tail = 0;
    int n_pop = 0;
    int n_sort = 0;
    int n_deep_sort = 0;
    int n_full_drop = 0;
    int n_empty_pop = 0;
    int peak_fill = 0;

    // mostly zero or short gaps, now and then a long one, and stretches of none
    function automatic int draw_gap(input int side);
        int roll;
        if (quiet_left[side] > 0) begin
            quiet_left[side]--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            quiet_left[side] = $urandom_range(30, 80);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // apply one accepted operation to the shadow deque and queue its reply
    function automatic void apply_deque_op(input logic [OP_W-1:0] op,
                                           input logic signed [VALUE_W-1:0] val);
        t_result                   reply;
        logic signed [VALUE_W-1:0] swap;
        int                        pi;
        int                        pj;
        reply.value  = '0;
        reply.status = ST_OK;
        case (op)
            OP_PUSH_HEAD: begin
                n_push_head++;
                if (shadow_fill >= DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_store[shadow_head] = val;
                    shadow_fill++;
                end
            end
            OP_PUSH_TAIL: begin
                n_push_tail++;
                if (shadow_fill >= DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    shadow_store[(shadow_head + shadow_fill) % DEPTH] = val;
                    shadow_fill++;
                end
            end
            OP_POP_TAIL: begin
                n_pop++;
                if (shadow_fill == 0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    reply.value = shadow_store[(shadow_head + shadow_fill - 1) % DEPTH];
                    shadow_fill--;
                end
            end
            default: begin
                // exchange sort head to tail; equal values stay where they are
                n_sort++;
                if (shadow_fill > 1) n_deep_sort++;
                for (int i = 0; i + 1 < shadow_fill; i++) begin
                    for (int j = i + 1; j < shadow_fill; j++) begin
                        pi = (shadow_head + i) % DEPTH;
                        pj = (shadow_head + j) % DEPTH;
                        if (shadow_store[pi] > shadow_store[pj]) begin
                            swap = shadow_store[pi];
                            shadow_store[pi] = shadow_store[pj];
                            shadow_store[pj] = swap;
                        end
                    end
                end
            end
        endcase
        if (reply.status == ST_FULL) n_full_drop++;
        if (reply.status == ST_EMPTY) n_empty_pop++;
        if (shadow_fill > peak_fill) peak_fill = shadow_fill;
        reply.count = CNT_OUT_W'(shadow_fill);
        reply_queue.push_back(reply);
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("%0t ns reply %0d: %s got %h want %h", $time, reply_index, what, got, want);
    endtask

    task automatic add_op(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] val,
                          input logic hold);
        t_op_item item;
        item.hold = hold;
        item.op   = op;
        item.val  = val;
        op_backlog.push_back(item);
    endtask

    // sender: holds valid and payload until the transfer, then waits out a gap
    always @(posedge i_clk) begin
        t_op_item item;
        logic     valid_next;
        valid_next = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                apply_deque_op(i_operation, i_value);
                valid_next = 1'b0;
                send_gap = draw_gap(0);
            end
            if (!valid_next) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (op_backlog.size() > 0) begin
                    if (op_backlog[0].hold) begin
                        // drain point: release only once the deque owes nothing
                        if (reply_queue.size() == 0) void'(op_backlog.pop_front());
                    end else begin
                        item = op_backlog.pop_front();
                        i_operation <= item.op;
                        i_value     <= item.val;
                        valid_next  = 1'b1;
                    end
                end
            end
        end
        i_in_valid <= valid_next;
    end

    // receiver: random stall bursts on the result channel
    always @(posedge i_clk) begin
        logic stall_next;
        stall_next = 1'b0;
        if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_left = draw_gap(1);
        end
        i_out_stall <= stall_next;
    end

    // monitor: every result transfer is checked against the oldest awaited reply
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (reply_queue.size() == 0) begin
                report_mismatch("result transfer with nothing awaited", o_popped_value, '0);
            end else begin
                want = reply_queue.pop_front();
                if (o_popped_value !== want.value)
                    report_mismatch("popped value", o_popped_value, want.value);
                if (o_entry_count !== want.count)
                    report_mismatch("entry count", VALUE_W'(o_entry_count), VALUE_W'(want.count));
                if (o_status !== want.status)
                    report_mismatch("status", VALUE_W'(o_status), VALUE_W'(want.status));
            end
            reply_index++;
        end
    end

    // stimulus, reset, and the end of the run
    initial begin
        logic signed [VALUE_W-1:0] fill_vals[16];
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] val;
        int                        mode;
        int                        roll;
        int                        push_pct;

        fill_vals = '{32'sd3, -32'sd1, 32'sh7FFF_FFFF, 32'sd0, 32'sd3, 32'sh8000_0000,
                      -32'sd1, 32'sd1, 32'sh7FFF_FFFF, 32'sd0, -32'sd5, 32'sd3,
                      32'sh8000_0000, 32'sd1, 32'sd2, -32'sd1};

        // empty deque: pop fails, sort is a no-op, value field is ignored
        add_op(OP_POP_TAIL, 32'sh1234_5678, 1'b0);
        add_op(OP_SORT, -32'sd1, 1'b0);
        // the two extremes out of order, sorted, then popped down to empty
        add_op(OP_PUSH_HEAD, 32'sh7FFF_FFFF, 1'b0);
        add_op(OP_PUSH_TAIL, 32'sh8000_0000, 1'b0);
        add_op(OP_SORT, 32'sh5A5A_A5A5, 1'b0);
        add_op(OP_POP_TAIL, 32'sh0F0F_F0F0, 1'b0);
        add_op(OP_POP_TAIL, 32'sh0000_0000, 1'b0);
        // fill from both ends with duplicates, overflow on both ends, sort when full
        for (int k = 0; k < DEPTH; k++)
            add_op((k % 2 == 0) ? OP_PUSH_TAIL : OP_PUSH_HEAD, fill_vals[k % 16], 1'b0);
        add_op(OP_PUSH_HEAD, 32'sd42, 1'b0);
        add_op(OP_PUSH_TAIL, -32'sd42, 1'b0);
        add_op(OP_SORT, 32'sd0, 1'b0);
        add_op(OP_PUSH_HEAD, '0, 1'b1);

        // random part: segments biased toward filling, draining or neither
        mode = 0;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 40 == 0) mode = $urandom_range(0, 2);
            if (n % 175 == 174) add_op(OP_PUSH_HEAD, '0, 1'b1);
            push_pct = (mode == 0) ? 75 : (mode == 1) ? 30 : 50;
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                case ($urandom_range(0, 3))
                    0:       val = 32'sh7FFF_FFFF;
                    1:       val = 32'sh8000_0000;
                    2:       val = 32'sd0;
                    default: val = -32'sd1;
                endcase
            end else if (roll < 4) begin
                // narrow range so the sort meets plenty of equal values
                val = $signed($urandom_range(0, 8)) - 32'sd4;
            end else begin
                val = $urandom;
            end
            if ($urandom_range(0, 99) < 7) begin
                op = OP_SORT;
            end else if ($urandom_range(0, 99) < push_pct) begin
                op = $urandom_range(0, 1) ? OP_PUSH_TAIL : OP_PUSH_HEAD;
            end else begin
                op = OP_POP_TAIL;
            end
            add_op(op, val, 1'b0);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything sent, everything answered, then a full sort's worth of quiet
        while (op_backlog.size() != 0 || i_in_valid || reply_queue.size() != 0)
            @(posedge i_clk);
        repeat (160) @(posedge i_clk);

        if (reply_queue.size() != 0)
            report_mismatch("replies never delivered", VALUE_W'(reply_queue.size()), '0);
        $display("covered %0d transfers: %0d head pushes, %0d tail pushes, %0d pops, %0d sorts",
                 reply_index, n_push_head, n_push_tail, n_pop, n_sort);
        $display("%0d sorts on 2+ entries, %0d full drops, %0d empty pops, peak fill %0d/%0d",
                 n_deep_sort, n_full_drop, n_empty_pop, peak_fill, DEPTH);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/dqxs_pkg.sv
rtl/dqxs_ram.sv
rtl/deque_with_exchange_sort.sv
tb/sv/deque_with_exchange_sort_tb.sv
